// File: rtl/core/lru_pkg.sv
package lru_pkg;

    localparam int DEPTH_DEF     = 512;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CAP_W         = 10;
    localparam int CNT_W         = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_WRITE,
        S_PUBLISH
    } t_state;

    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic write;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic srch_done;
        logic srch_hit;
        logic room;
        logic shift_done;
        logic out_free;
    } t_status;

endpackage

// File: rtl/core/lru_ctrl.sv
module lru_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lru_pkg::t_status i_status,
    output lru_pkg::t_cmd    o_cmd
);
    import lru_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.srch_done) begin
                    if (i_status.srch_hit || !i_status.room) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_SHIFT: begin
                if (i_status.shift_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_PUBLISH;
            end
            S_PUBLISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
            end
            S_PUBLISH: begin
                o_cmd.publish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/lru_dpath.sv
module lru_dpath #(
    parameter int DEPTH     = lru_pkg::DEPTH_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [PAGE_BITS-1:0]       i_page,
    input  logic                       i_cfg_valid,
    input  logic [lru_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                       i_ready,
    input  lru_pkg::t_cmd              i_cmd,
    output lru_pkg::t_status           o_status,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic                       o_evicted_valid,
    output logic [PAGE_BITS-1:0]       o_evicted_page,
    output logic [lru_pkg::CNT_W-1:0]  o_hit_count,
    output logic [lru_pkg::CNT_W-1:0]  o_access_count
);
    import lru_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    // Entries are kept in recency order: position 0 is least recent.
    logic [PAGE_BITS-1:0] r_mem [DEPTH];
    logic [PAGE_BITS-1:0] r_rd_data;

    logic [CAP_W-1:0]     r_cap;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_rptr;
    logic [AW-1:0]        r_cptr;
    logic                 r_dv;
    logic                 r_hit;
    logic                 r_evict;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_accesses;
    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] r_ev_page;
    logic                 r_out_hit;
    logic                 r_out_ev;
    logic [PAGE_BITS-1:0] r_out_ev_page;

    logic                 rd_more;
    logic                 srch_hit;
    logic                 srch_done;
    logic                 room;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [PAGE_BITS-1:0] wr_data;
    logic [AW-1:0]        last_pos;

    assign rd_more   = r_rptr < r_n;
    assign srch_hit  = r_dv && (r_rd_data == r_page);
    assign srch_done = srch_hit || (!r_dv && !rd_more);
    assign last_pos  = AW'(r_n - CW'(1));

    always_comb begin
        if (r_cap == '0) begin
            room = (r_n == '0);
        end else begin
            room = (r_n < CW'(DEPTH)) && (EW'(r_n) < EW'(r_cap));
        end
    end

    assign o_status.srch_done  = srch_done;
    assign o_status.srch_hit   = srch_hit;
    assign o_status.room       = room;
    assign o_status.shift_done = !r_dv && !rd_more;
    assign o_status.out_free   = !r_out_valid || i_ready;

    assign rd_en   = ((i_cmd.search && !srch_done) || i_cmd.shift) && rd_more;
    assign rd_addr = r_rptr[AW-1:0];
    assign wr_en   = (i_cmd.shift && r_dv) || i_cmd.write;
    assign wr_data = i_cmd.write ? r_page : r_rd_data;

    always_comb begin
        if (i_cmd.write) begin
            wr_addr = (r_hit || r_evict) ? last_pos : r_n[AW-1:0];
        end else begin
            wr_addr = r_cptr - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_n         <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_accesses  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_dv <= 1'b0;
            end else if (i_cmd.search && srch_done) begin
                r_dv <= 1'b0;
            end else if (i_cmd.search || i_cmd.shift) begin
                r_dv <= rd_more;
            end
            if (i_cmd.write && !r_hit && !r_evict) begin
                r_n <= r_n + CW'(1);
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_accesses  <= (&r_accesses) ? r_accesses : r_accesses + CNT_W'(1);
                if (r_hit && !(&r_hits)) begin
                    r_hits <= r_hits + CNT_W'(1);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_page;
            r_rptr <= '0;
        end else if (i_cmd.search && srch_done) begin
            r_hit   <= srch_hit;
            r_evict <= !srch_hit && !room;
            r_rptr  <= (srch_hit ? CW'(r_cptr) : CW'(0)) + CW'(1);
        end else if ((i_cmd.search || i_cmd.shift) && rd_more) begin
            r_cptr <= r_rptr[AW-1:0];
            r_rptr <= r_rptr + CW'(1);
        end
        if (i_cmd.search && r_dv && (r_cptr == '0)) begin
            r_ev_page <= r_rd_data;
        end
        if (i_cmd.publish) begin
            r_out_hit     <= r_hit;
            r_out_ev      <= r_evict;
            r_out_ev_page <= r_evict ? r_ev_page : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_evicted_valid = r_out_ev;
    assign o_evicted_page  = r_out_ev_page;
    assign o_hit_count     = r_hits;
    assign o_access_count  = r_accesses;

endmodule

// File: rtl/core/lru_page_replacement.sv
// A hit and a miss that evicts both scan and then shift the resident pages;
// a miss with a free frame scans them and then writes the new page.
// The page store is scanned one entry per cycle, and a result held by the receiver adds its stall.
// One access is in flight at a time; the next beat is taken the cycle after a result is formed.
// Synchronous reset clears the counters and the resident count and sets capacity to 512.
// The page store itself is not cleared; no clearing pass is needed.
module lru_page_replacement #(
    parameter int DEPTH     = lru_pkg::DEPTH_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lru_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [PAGE_BITS-1:0]       i_page,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output logic                       o_evicted_valid,
    output logic [PAGE_BITS-1:0]       o_evicted_page,
    output logic [lru_pkg::CNT_W-1:0]  o_hit_count,
    output logic [lru_pkg::CNT_W-1:0]  o_access_count
);
    import lru_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    lru_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lru_dpath #(
        .DEPTH     (DEPTH),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_page          (i_page),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_ready         (i_ready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_count     (o_hit_count),
        .o_access_count  (o_access_count)
    );

endmodule

// File: rtl/core/lru_chk.sv
module lru_chk #(
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_hit,
    input logic                       o_evicted_valid,
    input logic [PAGE_BITS-1:0]       o_evicted_page,
    input logic [lru_pkg::CNT_W-1:0]  o_hit_count,
    input logic [lru_pkg::CNT_W-1:0]  o_access_count
);

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted again right after a beat");

    a_hit_or_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted_valid))
        else $error("result reports both a hit and an eviction");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page not zero without an eviction");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_count <= o_access_count))
        else $error("hit count exceeds access count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_access_count)))
        else $error("stalled result beat changed or dropped");

endmodule

bind lru_page_replacement lru_chk #(.PAGE_BITS(PAGE_BITS)) u_lru_chk (.*);
